// ===== sv/lzrle_pkg.sv =====
// Package for the LZ/RLE byte decompressor: phase codes, commands, error codes.
// No dependencies.
package lzrle_pkg;

  localparam int HistDepthDefault = 65536;
  localparam logic [16:0] MaxLenReset = 17'd65536;
  localparam logic [7:0] EndMarker = 8'hFF;

  typedef enum logic [8:0] {
    PH_HEADER  = 9'b000000001,
    PH_LONG    = 9'b000000010,
    PH_OFF_HI  = 9'b000000100,
    PH_OFF_LO  = 9'b000001000,
    PH_LITERAL = 9'b000010000,
    PH_FILL    = 9'b000100000,
    PH_WORD_A  = 9'b001000000,
    PH_WORD_B  = 9'b010000000,
    PH_RUN     = 9'b100000000
  } phase_t;

  localparam logic [2:0] CMD_LIT   = 3'd0;
  localparam logic [2:0] CMD_FILL  = 3'd1;
  localparam logic [2:0] CMD_WORD  = 3'd2;
  localparam logic [2:0] CMD_INC   = 3'd3;
  localparam logic [2:0] CMD_COPY  = 3'd4;
  localparam logic [2:0] CMD_FLIP  = 3'd5;
  localparam logic [2:0] CMD_DESC  = 3'd6;
  localparam logic [2:0] CMD_LONG  = 3'd7;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_OVF   = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;
  localparam logic [1:0] ERR_CMD   = 2'd3;

  typedef struct packed {
    logic       we;
    logic [15:0] addr;
    logic [7:0] data;
  } hist_wr_t;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int b = 0; b < 8; b++) r[7-b] = v[b];
    return r;
  endfunction

endpackage

// ===== sv/lzrle_hist.sv =====
// History store with a clearing pass after reset; one write and one read port,
// registered read. Depends on lzrle_pkg.
module lzrle_hist import lzrle_pkg::*; #(
  parameter int HISTORY_DEPTH = HistDepthDefault,
  parameter int AW = $clog2(HISTORY_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  hist_wr_t      wr,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata,
  output logic          clearing
);
  logic [7:0] mem [HISTORY_DEPTH];
  logic [AW:0] clr_cnt;

  assign clearing = !clr_cnt[AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[AW-1:0]] <= 8'h00;
    end else if (wr.we) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/lz_rle_byte_decompressor_unit.sv =====
// Top level of the LZ/RLE byte decompressor: header/run control and output stage.
// Depends on lzrle_pkg and lzrle_hist.
//
// Usage: items enter on the input channel (valid/stall) with operation and
// in_byte; operation 0 feeds a compressed byte, 1 advances one run byte.
// Every item yields one result item on the output channel (valid/stall):
// accepted, out_valid, out_byte, out_index, need_byte, done_res, error_code.
// max_length is written through cfg_valid/cfg_ready/cfg_data; the user must
// do so only while idle, as the block itself does not enforce it. An item can
// enter every cycle while in_stall is low. A back-copy byte is read from the
// history memory ahead of its use; a byte written in the previous cycle is
// forwarded to the read. After reset all HISTORY_DEPTH history entries are
// cleared, one entry a cycle; no item is taken during that pass.
// Output stall backs up through a two-entry result buffer: input stall rises
// when the buffer, after this cycle's pop, cannot take the item in flight
// plus one more.
module lz_rle_byte_decompressor_unit import lzrle_pkg::*; #(
  parameter int HISTORY_DEPTH = HistDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  in_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data,
  output logic        out_valid_ch,
  input  logic        out_stall,
  output logic        accepted,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic [15:0] out_index,
  output logic        need_byte,
  output logic        done_res,
  output logic [1:0]  error_code
);
  localparam int AW = $clog2(HISTORY_DEPTH);

  typedef struct packed {
    logic        accepted;
    logic        ovalid;
    logic [7:0]  obyte;
    logic [15:0] oindex;
    logic        need;
    logic        done;
    logic [1:0]  err;
  } res_t;

  // state
  logic [16:0] max_length;
  phase_t      phase;
  logic [2:0]  command;
  logic [10:0] remaining;
  logic        second_half;
  logic [16:0] write_position;
  logic [16:0] reference_position;
  logic [7:0]  fill_first, fill_second;
  logic [1:0]  error_state;
  logic        finished;

  // stage 1: accepted item waiting for history data
  logic        s1_valid;
  logic        s1_op;
  logic [7:0]  s1_byte;

  hist_wr_t    wr;
  logic [AW-1:0] raddr;
  logic [7:0]  rdata;
  logic        clearing;

  // result buffer (two entries)
  res_t        buf0, buf1;
  logic [1:0]  cnt;
  logic        pop;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MaxLenReset;
    end else if (cfg_valid) begin
      max_length <= cfg_data;
    end
  end

  assign pop = (cnt != 2'd0) && !out_stall;

  // stall when buffer may overflow: buffered + in flight must leave room
  assign in_stall = clearing ||
                    (({1'b0, cnt} + {2'b00, s1_valid} - {2'b00, pop}) >= 3'd2);
  wire in_acc = in_valid && !in_stall;

  logic [16:0] write_position_next, reference_position_next;

  // read address: reference position for the next run byte
  assign raddr = reference_position_next[AW-1:0];

  lzrle_hist #(.HISTORY_DEPTH(HISTORY_DEPTH), .AW(AW)) u_hist (
    .clk(clk), .rst(rst), .wr(wr), .raddr(raddr), .rdata(rdata), .clearing(clearing)
  );

  // forwarding: the previous cycle's write to the address being read
  logic        fwd_hit;
  logic [7:0]  fwd_data;
  always_ff @(posedge clk) begin
    fwd_hit    <= wr.we && (wr.addr[AW-1:0] == raddr);
    fwd_data   <= wr.data;
  end
  wire [7:0] hist_byte = fwd_hit ? fwd_data : rdata;

  // ---------------- stage 1 processing ----------------
  logic [16:0] lim;
  res_t        res;
  phase_t      phase_next;
  logic [2:0]  command_next;
  logic [10:0] remaining_next;
  logic        second_half_next;
  logic [7:0]  fill_first_next, fill_second_next;
  logic [1:0]  error_state_next;
  logic        finished_next;
  logic        frozen, want_feed, take;
  logic [7:0]  ebyte;
  logic        emit;
  logic [10:0] rem_h;
  logic [2:0]  cmd_h;
  logic        start;
  logic [17:0] sum1, sum2, rsum;

  assign lim = max_length[16] ? MaxLenReset : max_length;

  always_comb begin
    phase_next = phase;
    command_next = command;
    remaining_next = remaining;
    second_half_next = second_half;
    write_position_next = write_position;
    reference_position_next = reference_position;
    fill_first_next = fill_first;
    fill_second_next = fill_second;
    error_state_next = error_state;
    finished_next = finished;
    ebyte = 8'h00;
    emit = 1'b0;
    start = 1'b0;
    rem_h = remaining;
    cmd_h = command;
    sum1 = '0;
    sum2 = '0;
    rsum = '0;
    wr = '0;
    frozen = (error_state != ERR_NONE) || finished;
    want_feed = (phase != PH_RUN);
    take = s1_valid && !frozen && ((s1_op == 1'b0) == want_feed);
    if (take) begin
      unique case (phase)
        PH_HEADER: begin
          if (s1_byte == EndMarker) begin
            finished_next = 1'b1;
          end else if (s1_byte[7:5] == CMD_LONG) begin
            command_next = s1_byte[4:2];
            remaining_next = {9'd0, s1_byte[1:0]};
            phase_next = PH_LONG;
          end else begin
            cmd_h = s1_byte[7:5];
            rem_h = {6'd0, s1_byte[4:0]} + 11'd1;
            command_next = cmd_h;
            remaining_next = rem_h;
            start = 1'b1;
          end
        end
        PH_LONG: begin
          rem_h = {remaining[1:0], s1_byte} + 11'd1;
          remaining_next = rem_h;
          start = 1'b1;
        end
        PH_OFF_HI: begin
          reference_position_next = {1'b0, s1_byte, 8'h00};
          phase_next = PH_OFF_LO;
        end
        PH_OFF_LO: begin
          reference_position_next = {1'b0, reference_position[15:8], s1_byte};
          rsum = {1'b0, reference_position_next} + {7'd0, remaining};
          if (reference_position_next >= lim) begin
            error_state_next = ERR_RANGE;
          end else if (command == CMD_COPY || command == CMD_FLIP) begin
            if (rsum > {1'b0, lim}) error_state_next = ERR_RANGE;
            else phase_next = PH_RUN;
          end else if (command == CMD_DESC) begin
            if ({1'b0, reference_position_next} + 18'd1 < {7'd0, remaining})
              error_state_next = ERR_RANGE;
            else phase_next = PH_RUN;
          end else begin
            error_state_next = ERR_CMD;
          end
        end
        PH_LITERAL: begin
          emit = 1'b1;
          ebyte = s1_byte;
          remaining_next = remaining - 11'd1;
          if (remaining_next == 11'd0) phase_next = PH_HEADER;
        end
        PH_FILL: begin
          fill_first_next = s1_byte;
          phase_next = PH_RUN;
        end
        PH_WORD_A: begin
          fill_first_next = s1_byte;
          phase_next = PH_WORD_B;
        end
        PH_WORD_B: begin
          fill_second_next = s1_byte;
          second_half_next = 1'b0;
          phase_next = PH_RUN;
        end
        PH_RUN: begin
          emit = 1'b1;
          remaining_next = remaining - 11'd1;
          unique case (command)
            CMD_FILL: ebyte = fill_first;
            CMD_WORD: begin
              ebyte = second_half ? fill_second : fill_first;
              remaining_next = second_half ? remaining - 11'd1 : remaining;
              second_half_next = !second_half;
            end
            CMD_INC: begin
              ebyte = fill_first;
              fill_first_next = fill_first + 8'd1;
            end
            CMD_COPY: begin
              ebyte = hist_byte;
              reference_position_next = reference_position + 17'd1;
            end
            CMD_FLIP: begin
              ebyte = flip8(hist_byte);
              reference_position_next = reference_position + 17'd1;
            end
            default: begin
              ebyte = hist_byte;
              reference_position_next = reference_position - 17'd1;
            end
          endcase
          if (remaining_next == 11'd0) phase_next = PH_HEADER;
        end
        default: ;
      endcase
      if (start) begin
        sum1 = {1'b0, write_position} + {7'd0, rem_h};
        sum2 = {1'b0, write_position} + {6'd0, rem_h, 1'b0};
        if (sum1 > {1'b0, lim}) begin
          error_state_next = ERR_OVF;
        end else if (command_next >= CMD_COPY) begin
          phase_next = PH_OFF_HI;
        end else if (command_next == CMD_LIT) begin
          phase_next = PH_LITERAL;
        end else if (command_next == CMD_WORD) begin
          if (sum2 > {1'b0, lim}) error_state_next = ERR_OVF;
          else phase_next = PH_WORD_A;
        end else begin
          phase_next = PH_FILL;
        end
      end
      if (emit) begin
        wr.we = 1'b1;
        wr.addr = write_position[15:0];
        wr.data = ebyte;
        write_position_next = write_position + 17'd1;
      end
    end
    res.accepted = take;
    res.ovalid = emit;
    res.obyte = emit ? ebyte : 8'h00;
    res.oindex = emit ? write_position[15:0] : 16'h0000;
    res.need = !((error_state_next != ERR_NONE) || finished_next) && (phase_next != PH_RUN);
    res.done = finished_next;
    res.err = error_state_next;
  end

  // the memory is read with the updated reference, so its data is ready
  // when the next item reaches stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      command <= '0;
      remaining <= '0;
      second_half <= 1'b0;
      write_position <= '0;
      reference_position <= '0;
      fill_first <= '0;
      fill_second <= '0;
      error_state <= ERR_NONE;
      finished <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      command <= command_next;
      remaining <= remaining_next;
      second_half <= second_half_next;
      write_position <= write_position_next;
      reference_position <= reference_position_next;
      fill_first <= fill_first_next;
      fill_second <= fill_second_next;
      error_state <= error_state_next;
      finished <= finished_next;
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op <= operation;
      s1_byte <= in_byte;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {1'b0, s1_valid} - {1'b0, pop};
    end
  end
  always_ff @(posedge clk) begin
    if (pop) begin
      buf0 <= (cnt == 2'd2) ? buf1 : res;
      if (cnt == 2'd2 && s1_valid) buf1 <= res;
    end else if (s1_valid) begin
      if (cnt == 2'd0) buf0 <= res;
      else buf1 <= res;
    end
  end

  assign out_valid_ch = (cnt != 2'd0);
  assign accepted   = buf0.accepted;
  assign out_valid  = buf0.ovalid;
  assign out_byte   = buf0.obyte;
  assign out_index  = buf0.oindex;
  assign need_byte  = buf0.need;
  assign done_res   = buf0.done;
  assign error_code = buf0.err;
endmodule
